### rtl/mft_pkg.sv
// shared types, constants and codes of the manchester frame transmitter
package mft_pkg;

	// default transmit buffer depth in bytes
	localparam int DEF_BUFFER_BYTES = 16;

	// payload widths
	localparam int DATA_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// item kinds
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_POLARITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_POLARITY  = 2'd1;

	// line constants
	localparam logic       IDLE_LEVEL    = 1'b1;
	localparam logic [2:0] BIT_MSB       = 3'd7;
	localparam logic [2:0] BIT_LSB       = 3'd0;
	localparam logic [1:0] START_HALVES  = 2'd2;

	// polarity settings handed to the engine
	typedef struct packed {
		logic phase_polarity;
		logic line_polarity;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic line_drive;
		logic line_level;
		logic frame_done;
		logic load_rejected;
	} res_t;

endpackage

### rtl/mft_ifs.sv
// handshake interfaces of the manchester frame transmitter

// command channel: tick or byte load
interface mft_cmd_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [mft_pkg::DATA_W-1:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// result channel: one item per command
interface mft_res_if;
	logic valid;
	logic ready;
	logic line_drive;
	logic line_level;
	logic frame_done;
	logic load_rejected;

	modport source (output valid, output line_drive, output line_level,
		output frame_done, output load_rejected, input ready);
	modport sink   (input valid, input line_drive, input line_level,
		input frame_done, input load_rejected, output ready);
endinterface

// configuration write channel
interface mft_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mft_pkg::CFG_IDX_W-1:0]  index;
	logic [mft_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mft_ram.sv
// generic single write port ram with registered read
module mft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/mft_engine.sv
// frame state, byte buffer and line level logic of the transmitter
module mft_engine #(
	parameter int BUFFER_BYTES = mft_pkg::DEF_BUFFER_BYTES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic                       kind,
	input  logic [mft_pkg::DATA_W-1:0] data_byte,
	input  mft_pkg::cfg_t              cfg,
	output mft_pkg::res_t              res
);
	import mft_pkg::*;

	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
	localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(BUFFER_BYTES);
	localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

	logic [CNT_W-1:0]  byte_count_q, byte_count_n;
	logic [CNT_W-1:0]  byte_index_q, byte_index_n;
	logic [2:0]        bit_index_q, bit_index_n;
	logic [1:0]        start_q, start_n;
	logic              half_phase_q, half_phase_n;
	logic              idle_pending_q, idle_pending_n;
	logic [DATA_W-1:0] cur_q, cur_n;
	logic              byp_q, byp_n;
	logic [DATA_W-1:0] byp_data_q;

	logic              we;
	logic [CNT_W-1:0]  rd_next;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] nxt_byte;
	logic              positive;
	logic              data_bit;
	logic              empty;

	// nxt_byte holds the byte after the current one, from the ram or from the write bypass
	assign nxt_byte = byp_q ? byp_data_q : ram_rdata;
	assign empty    = (byte_index_q >= byte_count_q);
	assign positive = (half_phase_q == cfg.phase_polarity);
	assign data_bit = cur_q[bit_index_q];

	// next state and result of the accepted item
	always_comb begin
		byte_count_n   = byte_count_q;
		byte_index_n   = byte_index_q;
		bit_index_n    = bit_index_q;
		start_n        = start_q;
		half_phase_n   = half_phase_q;
		idle_pending_n = idle_pending_q;
		cur_n          = cur_q;
		we             = 1'b0;
		res            = '0;
		if (step) begin
			if (kind == KIND_LOAD) begin
				if (byte_count_q >= FULL) begin
					res.load_rejected = 1'b1;
				end else begin
					we           = 1'b1;
					byte_count_n = byte_count_q + ONE;
					if (empty) begin
						cur_n = data_byte;
					end
				end
			end else if (empty) begin
				if (idle_pending_q) begin
					res.line_drive = 1'b1;
					res.line_level = IDLE_LEVEL ^ cfg.line_polarity;
					idle_pending_n = 1'b0;
				end
			end else begin
				res.line_drive = 1'b1;
				half_phase_n   = ~half_phase_q;
				if (start_q < START_HALVES) begin
					// start bit halves
					res.line_level = (~positive) ^ cfg.line_polarity;
					start_n        = start_q + 2'd1;
				end else begin
					res.line_level = (positive ? ~data_bit : data_bit) ^ cfg.line_polarity;
					if (half_phase_q) begin
						// second half of a bit ends it
						if (bit_index_q == BIT_LSB) begin
							bit_index_n  = BIT_MSB;
							byte_index_n = byte_index_q + ONE;
							if ((byte_index_q + ONE) >= byte_count_q) begin
								byte_count_n   = '0;
								byte_index_n   = '0;
								start_n        = '0;
								half_phase_n   = 1'b0;
								idle_pending_n = 1'b1;
								res.frame_done = 1'b1;
							end else begin
								cur_n = nxt_byte;
							end
						end else begin
							bit_index_n = bit_index_q - 3'd1;
						end
					end
				end
			end
		end
	end

	// prefetch address and write bypass for the same entry
	assign rd_next = byte_index_n + ONE;
	assign byp_n   = we && (byte_count_q == rd_next);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			byte_index_q   <= '0;
			bit_index_q    <= BIT_MSB;
			start_q        <= '0;
			half_phase_q   <= 1'b0;
			idle_pending_q <= 1'b0;
			byp_q          <= 1'b0;
		end else begin
			byte_count_q   <= byte_count_n;
			byte_index_q   <= byte_index_n;
			bit_index_q    <= bit_index_n;
			start_q        <= start_n;
			half_phase_q   <= half_phase_n;
			idle_pending_q <= idle_pending_n;
			byp_q          <= byp_n;
		end
	end

	// current byte and bypass data
	always_ff @(posedge clk) begin
		cur_q      <= cur_n;
		byp_data_q <= data_byte;
	end

	// transmit byte buffer
	mft_ram #(
		.WIDTH (DATA_W),
		.DEPTH (BUFFER_BYTES),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(byte_count_q[ADDR_W-1:0]),
		.wdata(data_byte),
		.raddr(rd_next[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

endmodule

### rtl/manchester_frame_transmitter_unit.sv
// top level of the manchester frame transmitter
//
// Channels: cmd takes one item per half-bit tick (kind tick) or per byte to
// append to the transmit buffer (kind load). res returns exactly one item per
// command: the line drive and level for a tick, frame done on the tick that
// ends the last buffered bit, and load rejected when a load finds the buffer
// full. cfg writes phase_polarity (index 0) and line_polarity (index 1), bit 0
// of the data; other indexes are dropped. cfg is always ready.
// A result is registered: it sits in the output register from the cycle after
// its command is taken. Throughput: one item per cycle while res is ready; the
// buffer ram prefetches the next byte each cycle, so bytes follow without a gap.
// Reset: buffer empty, bit pointer at the msb, no idle level pending, both
// polarities zero, no result pending. The buffer contents need no clearing.
// Stall: while a result waits and res is not ready, cmd ready is low and the
// result holds; a command is taken in the same cycle the result is taken.
module manchester_frame_transmitter_unit #(
	parameter int BUFFER_BYTES = mft_pkg::DEF_BUFFER_BYTES
) (
	input logic       clk,
	input logic       arst_n,
	mft_cmd_if.sink   cmd,
	mft_res_if.source res,
	mft_cfg_if.sink   cfg
);
	import mft_pkg::*;

	cfg_t cfg_q;
	res_t eng_res;
	res_t res_q;
	logic res_valid_q;
	logic step;

	// handshake
	assign cmd.ready = !res_valid_q || res.ready;
	assign step      = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	// polarity registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_PHASE_POLARITY) begin
				cfg_q.phase_polarity <= cfg.data[0];
			end else if (cfg.index == CFG_LINE_POLARITY) begin
				cfg_q.line_polarity <= cfg.data[0];
			end
		end
	end

	// frame engine
	mft_engine #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.kind     (cmd.kind),
		.data_byte(cmd.data_byte),
		.cfg      (cfg_q),
		.res      (eng_res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= eng_res;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.line_drive    = res_q.line_drive;
	assign res.line_level    = res_q.line_level;
	assign res.frame_done    = res_q.frame_done;
	assign res.load_rejected = res_q.load_rejected;

endmodule
